// File: src/bpc_pkg.sv
// bpc_pkg: shared types, constants and register indexes for the pressure compensation block
// no dependencies
`default_nettype none
package bpc_pkg;

  typedef struct packed {
    logic        action;
    logic [18:0] raw_value;
  } bpc_in_t;

  typedef struct packed {
    logic [31:0] value;
    logic        invalid;
  } bpc_out_t;

  // register indexes
  localparam logic [1:0] REG_CAL_A = 2'd0;
  localparam logic [1:0] REG_CAL_B = 2'd1;
  localparam logic [1:0] REG_CAL_C = 2'd2;
  localparam logic [1:0] REG_OSS   = 2'd3;

  localparam logic [31:0] TEMP_ROUND = 32'd8;
  localparam logic [31:0] B6_OFFSET  = 32'd4000;
  localparam logic [31:0] B4_OFFSET  = 32'd32768;
  localparam logic [31:0] B7_SCALE   = 32'd50000;
  localparam logic [31:0] FIN_MG     = 32'd3038;
  localparam logic [31:0] FIN_MH     = 32'hFFFFE343;
  localparam logic [31:0] FIN_MI     = 32'd3791;

  // serial multiplier: low 32 bits of a*b, two bits per cycle
  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } bpc_mul_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] p;
  } bpc_mul_rsp_t;

  // serial unsigned divider, one quotient bit per cycle
  typedef struct packed {
    logic        start;
    logic [31:0] n;
    logic [31:0] d;
  } bpc_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] q;
  } bpc_div_rsp_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    asr = 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

// File: src/barometer_pressure_compensation.sv
// barometer_pressure_compensation: top level, sequencer over one serial multiplier and divider
// depends on bpc_pkg, bpc_mul, bpc_div
//
//   channel | ports                         | direction
//   in      | in_valid, in_stall, in_data   | word in
//   out     | out_valid, out_stall, out_data| word out
//   cfg     | cfg_we, cfg_index, cfg_data   | register write
//
// a temperature word runs one product and one divide from acceptance to result
// a pressure word runs ten products and one divide
// a zero divisor ends a word early, before its divide is started
// products run on the shared multiplier, two bits per cycle, and quotients on the divider
// reset is synchronous and clears control, calibration registers and the kept b5 term
// in_stall is high while a word is in work; a finished result waits while out_stall holds
`default_nettype none
module barometer_pressure_compensation
  import bpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire bpc_in_t     in_data,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output bpc_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  // sequencer states
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_T1   = 5'd1;   // x1 = (raw-ac6)*ac5
  localparam logic [4:0] S_T2   = 5'd2;   // divide mc<<11 by den
  localparam logic [4:0] S_P1   = 5'd3;   // b6*b6
  localparam logic [4:0] S_P2   = 5'd4;   // sq*b2
  localparam logic [4:0] S_P3   = 5'd5;   // ac2*b6
  localparam logic [4:0] S_P4   = 5'd6;   // ac3*b6
  localparam logic [4:0] S_P5   = 5'd7;   // b1*sq
  localparam logic [4:0] S_P6   = 5'd8;   // ac4*(x3+32768)
  localparam logic [4:0] S_P7   = 5'd9;   // (raw-b3)*(50000>>oss)
  localparam logic [4:0] S_P8   = 5'd10;  // divide
  localparam logic [4:0] S_P9   = 5'd11;  // t*t
  localparam logic [4:0] S_P10  = 5'd12;  // x1*3038
  localparam logic [4:0] S_P11  = 5'd13;  // p*mh
  localparam logic [4:0] S_OUT  = 5'd14;
  localparam logic [4:0] S_T0   = 5'd15;
  localparam logic [4:0] S_P0   = 5'd16;

  logic [4:0]  state_r, state_nxt;
  logic        go_r, go_nxt;

  logic [63:0] cal_a_r, cal_b_r;
  logic [31:0] cal_c_r;
  logic [1:0]  oss_r;
  logic [31:0] b5_r, b5_nxt;

  logic [18:0] raw_r, raw_nxt;
  logic [31:0] t0_r, t0_nxt;    // x1 / b6
  logic [31:0] t1_r, t1_nxt;    // den / sq / b4
  logic [31:0] t2_r, t2_nxt;    // x3 accumulator / p
  logic [31:0] t3_r, t3_nxt;    // b3 / final x1 term
  logic [31:0] t4_r, t4_nxt;    // b7
  logic        neg_r, neg_nxt;  // quotient sign for temperature divide

  bpc_out_t    res_r, res_nxt;  // finished result waiting for the output word
  logic        ovalid_r, ovalid_nxt;
  bpc_out_t    odata_r, odata_nxt;

  bpc_mul_req_t mreq;
  bpc_mul_rsp_t mrsp;
  bpc_div_req_t dreq;
  bpc_div_rsp_t drsp;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, cb1, cb2, mc, md;
  logic [31:0] b3v, x3v, nmag, dmag, qv, fin;

  bpc_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  bpc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // calibration fields
  always_comb begin
    ac1 = sx16(cal_a_r[63:48]);
    ac2 = sx16(cal_a_r[47:32]);
    ac3 = sx16(cal_a_r[31:16]);
    ac4 = {16'd0, cal_a_r[15:0]};
    ac5 = {16'd0, cal_b_r[63:48]};
    ac6 = {16'd0, cal_b_r[47:32]};
    cb1 = sx16(cal_b_r[31:16]);
    cb2 = sx16(cal_b_r[15:0]);
    mc  = sx16(cal_c_r[31:16]);
    md  = sx16(cal_c_r[15:0]);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    go_nxt     = 1'b0;
    b5_nxt     = b5_r;
    raw_nxt    = raw_r;
    t0_nxt     = t0_r;
    t1_nxt     = t1_r;
    t2_nxt     = t2_r;
    t3_nxt     = t3_r;
    t4_nxt     = t4_r;
    neg_nxt    = neg_r;
    res_nxt    = res_r;
    ovalid_nxt = ovalid_r && out_stall;
    odata_nxt  = odata_r;
    mreq       = '0;
    dreq       = '0;
    b3v  = 32'd0;
    x3v  = 32'd0;
    nmag = 32'd0;
    dmag = 32'd0;
    qv   = 32'd0;
    fin  = 32'd0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          raw_nxt   = in_data.raw_value;
          state_nxt = in_data.action ? S_P0 : S_T0;
        end
      end
      S_T0: begin
        mreq = '{start: 1'b1, a: {13'd0, raw_r} - ac6, b: ac5};
        state_nxt = S_T1;
      end
      S_T1: if (mrsp.done) begin
        t0_nxt = asr(mrsp.p, 5'd15);
        t1_nxt = asr(mrsp.p, 5'd15) + md;
        if (asr(mrsp.p, 5'd15) + md == 32'd0) begin
          res_nxt = '{value: 32'd0, invalid: 1'b1};
          state_nxt = S_OUT;
        end else begin
          nmag = mc << 11;
          dmag = asr(mrsp.p, 5'd15) + md;
          neg_nxt = nmag[31] ^ dmag[31];
          dreq = '{start: 1'b1,
                   n: nmag[31] ? 32'd0 - nmag : nmag,
                   d: dmag[31] ? 32'd0 - dmag : dmag};
          state_nxt = S_T2;
        end
      end
      S_T2: if (drsp.done) begin
        qv = neg_r ? 32'd0 - drsp.q : drsp.q;
        b5_nxt = t0_r + qv;
        res_nxt = '{value: asr(t0_r + qv + TEMP_ROUND, 5'd4), invalid: 1'b0};
        state_nxt = S_OUT;
      end
      S_P0: begin
        t0_nxt = b5_r - B6_OFFSET;
        mreq = '{start: 1'b1, a: b5_r - B6_OFFSET, b: b5_r - B6_OFFSET};
        state_nxt = S_P1;
      end
      S_P1: if (mrsp.done) begin
        t1_nxt = asr(mrsp.p, 5'd12);
        mreq = '{start: 1'b1, a: asr(mrsp.p, 5'd12), b: cb2};
        state_nxt = S_P2;
      end
      S_P2: if (mrsp.done) begin
        t2_nxt = asr(mrsp.p, 5'd11);
        mreq = '{start: 1'b1, a: ac2, b: t0_r};
        state_nxt = S_P3;
      end
      S_P3: if (mrsp.done) begin
        x3v = t2_r + asr(mrsp.p, 5'd11);
        b3v = asr(((ac1 << 2) + x3v << oss_r) + 32'd2, 5'd2);
        t3_nxt = b3v;
        mreq = '{start: 1'b1, a: ac3, b: t0_r};
        state_nxt = S_P4;
      end
      S_P4: if (mrsp.done) begin
        t2_nxt = asr(mrsp.p, 5'd13);
        mreq = '{start: 1'b1, a: cb1, b: t1_r};
        state_nxt = S_P5;
      end
      S_P5: if (mrsp.done) begin
        x3v = asr(t2_r + asr(mrsp.p, 5'd16) + 32'd2, 5'd2);
        mreq = '{start: 1'b1, a: ac4, b: x3v + B4_OFFSET};
        state_nxt = S_P6;
      end
      S_P6: if (mrsp.done) begin
        t1_nxt = mrsp.p >> 15;
        mreq = '{start: 1'b1, a: {13'd0, raw_r} - t3_r, b: B7_SCALE >> oss_r};
        state_nxt = S_P7;
      end
      S_P7: if (mrsp.done) begin
        t4_nxt = mrsp.p;
        if (t1_r == 32'd0) begin
          res_nxt = '{value: 32'd0, invalid: 1'b1};
          state_nxt = S_OUT;
        end else begin
          dreq = '{start: 1'b1, n: mrsp.p[31] ? mrsp.p : {mrsp.p[30:0], 1'b0}, d: t1_r};
          state_nxt = S_P8;
        end
      end
      S_P8: if (drsp.done) begin
        qv = t4_r[31] ? {drsp.q[30:0], 1'b0} : drsp.q;
        t2_nxt = qv;
        mreq = '{start: 1'b1, a: asr(qv, 5'd8), b: asr(qv, 5'd8)};
        state_nxt = S_P9;
      end
      S_P9: if (mrsp.done) begin
        mreq = '{start: 1'b1, a: mrsp.p, b: FIN_MG};
        state_nxt = S_P10;
      end
      S_P10: if (mrsp.done) begin
        t3_nxt = asr(mrsp.p, 5'd16);
        mreq = '{start: 1'b1, a: t2_r, b: FIN_MH};
        state_nxt = S_P11;
      end
      S_P11: if (mrsp.done) begin
        fin = t2_r + asr(t3_r + asr(mrsp.p, 5'd16) + FIN_MI, 5'd4);
        res_nxt = '{value: fin, invalid: 1'b0};
        state_nxt = S_OUT;
      end
      // hand the result over once the output word is free
      S_OUT: begin
        if (!ovalid_r || !out_stall) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = res_r;
          go_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      go_r     <= 1'b0;
      ovalid_r <= 1'b0;
      b5_r     <= 32'd0;
      cal_a_r  <= 64'd0;
      cal_b_r  <= 64'd0;
      cal_c_r  <= 32'd0;
      oss_r    <= 2'd1;
    end else begin
      state_r  <= state_nxt;
      go_r     <= go_nxt;
      ovalid_r <= ovalid_nxt;
      b5_r     <= b5_nxt;
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_CAL_A: cal_a_r <= cfg_data;
          REG_CAL_B: cal_b_r <= cfg_data;
          REG_CAL_C: cal_c_r <= cfg_data[31:0];
          REG_OSS:   oss_r   <= cfg_data[1:0];
          default:   ;
        endcase
      end
    end
    raw_r   <= raw_nxt;
    t0_r    <= t0_nxt;
    t1_r    <= t1_nxt;
    t2_r    <= t2_nxt;
    t3_r    <= t3_nxt;
    t4_r    <= t4_nxt;
    neg_r   <= neg_nxt;
    res_r   <= res_nxt;
    odata_r <= odata_nxt;
  end

`ifndef SYNTHESIS
  // no new word while one is in work
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("accept while busy");
  // a result is raised only right after the output step
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> go_r)
    else $error("result without output step");
  // multiplier and divider never finish together
  a_unit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mrsp.done && drsp.done))
    else $error("both units done");
  // kept b5 changes only on a finished temperature divide
  a_b5_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(b5_r) |-> $past(state_r) == S_T2)
    else $error("b5 changed outside temperature");
`endif

endmodule
`default_nettype wire

// File: src/bpc_mul.sv
// bpc_mul: shift-add multiplier, multiplier word shifted out two bits per cycle
// depends on bpc_pkg
`default_nettype none
module bpc_mul
  import bpc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire bpc_mul_req_t req,
  output bpc_mul_rsp_t rsp
);

  logic [31:0] acc_r, acc_nxt;
  logic [31:0] mcand_r, mcand_nxt;
  logic [31:0] mplier_r, mplier_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] part;

  // two-bit digit times multiplicand
  always_comb begin
    part = (mplier_r[0] ? mcand_r : 32'd0) + (mplier_r[1] ? {mcand_r[30:0], 1'b0} : 32'd0);
  end

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      acc_nxt    = 32'd0;
      mcand_nxt  = req.a;
      mplier_nxt = req.b;
      cnt_nxt    = 5'd0;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      acc_nxt    = acc_r + part;
      mcand_nxt  = {mcand_r[29:0], 2'b00};
      mplier_nxt = {2'b00, mplier_r[31:2]};
      cnt_nxt    = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule
`default_nettype wire

// File: src/bpc_div.sv
// bpc_div: restoring unsigned divider, one quotient bit per cycle
// depends on bpc_pkg
`default_nettype none
module bpc_div
  import bpc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire bpc_div_req_t req,
  output bpc_div_rsp_t rsp
);

  logic [32:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [32:0] diff;

  // shift in one numerator bit and try a subtract
  always_comb begin
    trial = {rem_r[31:0], quo_r[31]};
    diff  = trial - {1'b0, den_r};
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = 33'd0;
      quo_nxt  = req.n;
      den_nxt  = req.d;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = quo_r;

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// tb_top: self-checking bench for barometer_pressure_compensation
// depends on bpc_pkg and the block; temperature and pressure words vs. an in-bench predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import bpc_pkg::*;

  localparam int SETTLE_CYCLES = 400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  bpc_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  bpc_out_t    out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  barometer_pressure_compensation u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state: calibration copy and kept b5 term
  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_c;
  logic [1:0]  oss_set;
  logic [31:0] kept_b5;

  bpc_out_t    comp_queue[$];
  int          send_gap_pct;
  int          recv_gap_pct;
  bit          hold_recv;
  int          err_count = 0;
  int          words_sent;
  int          words_checked = 0;
  int          bad_seen = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] shr_s(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // signed divide truncating toward zero
  function automatic logic [31:0] div_s(input logic [31:0] n, input logic [31:0] d);
    logic [31:0] mn, md, q;
    mn = n[31] ? -n : n;
    md = d[31] ? -d : d;
    q = mn / md;
    return (n[31] != d[31]) ? -q : q;
  endfunction

  // expected result of one word, updating the kept b5 term
  function automatic bpc_out_t compensate(input bpc_in_t w);
    bpc_out_t r;
    logic [31:0] raw, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, den, b6, sq, b3, b4, b7, p;
    raw = {13'd0, w.raw_value};
    ac1 = ext16(cal_a[63:48]); ac2 = ext16(cal_a[47:32]);
    ac3 = ext16(cal_a[31:16]); ac4 = {16'd0, cal_a[15:0]};
    ac5 = {16'd0, cal_b[63:48]}; ac6 = {16'd0, cal_b[47:32]};
    b1 = ext16(cal_b[31:16]); b2 = ext16(cal_b[15:0]);
    mc = ext16(cal_c[31:16]); md = ext16(cal_c[15:0]);
    r = '0;
    if (!w.action) begin
      x1 = shr_s((raw - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 0) r.invalid = 1'b1;
      else begin
        x2 = div_s(mc << 11, den);
        kept_b5 = x1 + x2;
        r.value = shr_s(kept_b5 + 32'd8, 4);
      end
    end else begin
      b6 = kept_b5 - 32'd4000;
      sq = shr_s(b6 * b6, 12);
      x1 = shr_s(sq * b2, 11);
      x2 = shr_s(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = shr_s(((ac1 * 32'd4 + x3) << oss_set) + 32'd2, 2);
      x1 = shr_s(ac3 * b6, 13);
      x2 = shr_s(b1 * sq, 16);
      x3 = shr_s(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      b7 = (raw - b3) * (32'd50000 >> oss_set);
      if (b4 == 0) r.invalid = 1'b1;
      else begin
        if (!b7[31]) p = (b7 << 1) / b4;
        else p = (b7 / b4) << 1;
        x1 = shr_s(p, 8);
        x1 = x1 * x1;
        x1 = shr_s(x1 * 32'd3038, 16);
        x2 = shr_s(p * 32'hFFFFE343, 16);
        r.value = p + shr_s(x1 + x2 + 32'd3791, 4);
      end
    end
    return r;
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    bpc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_checked++;
      if (comp_queue.size() == 0) begin
        $display("%0t: unexpected word value=%h invalid=%b", $time,
                 out_data.value, out_data.invalid);
        err_count++;
      end else begin
        want = comp_queue.pop_front();
        if (want.value !== out_data.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, out_data.value);
          err_count++;
        end
        if (want.invalid !== out_data.invalid) begin
          $display("%0t: invalid expected %b actual %b", $time, want.invalid,
                   out_data.invalid);
          err_count++;
        end
        if (want.invalid) bad_seen++;
      end
    end
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_recv || ($urandom_range(99, 0) < recv_gap_pct);
  end

  // valid stays up after acceptance until an idle cycle or a drain drops it
  task automatic send_word(input logic act, input logic [18:0] raw);
    bpc_in_t w;
    while ($urandom_range(99, 0) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    w.action = act;
    w.raw_value = raw;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    comp_queue.push_back(compensate(w));
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (comp_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CAL_A: cal_a = d;
      REG_CAL_B: cal_b = d;
      REG_CAL_C: cal_c = d[31:0];
      REG_OSS:   oss_set = d[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // published sample calibration
  task automatic load_typical(input logic [1:0] oss);
    write_reg(REG_CAL_A, {16'sd408, -16'sd72, -16'sd14383, 16'd32741});
    write_reg(REG_CAL_B, {16'd32757, 16'd23153, 16'sd6190, 16'sd4});
    write_reg(REG_CAL_C, {32'd0, -16'sd8711, 16'sd2868});
    write_reg(REG_OSS, {62'd0, oss});
  endtask

  task automatic test_reset_defaults();
    // pressure before any temperature, all calibration zero: b4 zero
    send_word(1'b1, 19'd0);
    send_word(1'b0, 19'h7FFFF);
    send_word(1'b1, 19'h7FFFF);
    drain();
  endtask

  task automatic test_directed();
    load_typical(2'd0);
    send_word(1'b0, 19'd27898);
    send_word(1'b1, 19'd23843);
    send_word(1'b0, 19'd0);
    send_word(1'b0, 19'h7FFFF);
    send_word(1'b0, 19'h0FFFF);
    send_word(1'b1, 19'd0);
    send_word(1'b1, 19'h7FFFF);
    drain();
    load_typical(2'd3);
    send_word(1'b0, 19'd27898);
    send_word(1'b1, 19'h7FFFF);
    send_word(1'b1, 19'd0);
    drain();
    // zero temperature divisor: ac5 zero so x1 is 0, md zero
    write_reg(REG_CAL_B, 64'h0000_5A71_182E_0004);
    write_reg(REG_CAL_C, 64'h0000_0000_DDF9_0000);
    send_word(1'b0, 19'd12345);
    send_word(1'b1, 19'd40000);
    drain();
    // zero pressure divisor: ac4 zero
    write_reg(REG_CAL_A, 64'h0198_FFB8_C7D1_0000);
    send_word(1'b1, 19'd40000);
    drain();
    // extremes
    write_reg(REG_CAL_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_CAL_B, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_CAL_C, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(1'b0, 19'h7FFFF);
    send_word(1'b1, 19'h7FFFF);
    send_word(1'b0, 19'd0);
    send_word(1'b1, 19'd0);
    drain();
    write_reg(REG_CAL_A, 64'h8000_8000_8000_8000);
    write_reg(REG_CAL_B, 64'h8000_8000_8000_8000);
    write_reg(REG_CAL_C, 64'h0000_0000_7FFF_7FFF);
    send_word(1'b0, 19'h55555);
    send_word(1'b1, 19'h2AAAA);
    drain();
  endtask

  // mostly temperature then pressure pairs, some lone words
  task automatic test_random(input int count, input bit wild_cal);
    int k;
    for (k = 0; k < count; k++) begin
      if (k % 200 == 0) begin
        drain();
        if (wild_cal) begin
          write_reg(REG_CAL_A, {$urandom, $urandom});
          write_reg(REG_CAL_B, {$urandom, $urandom});
          write_reg(REG_CAL_C, {32'd0, $urandom});
          write_reg(REG_OSS, 64'($urandom_range(3, 0)));
        end else load_typical(2'($urandom_range(3, 0)));
      end
      if ($urandom_range(9, 0) < 8) begin
        send_word(1'b0, wild_cal ? 19'($urandom) : 19'($urandom_range(32000, 24000)));
        send_word(1'b1, 19'($urandom));
        k++;
      end else send_word(1'($urandom), 19'($urandom));
    end
    drain();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    int n;
    load_typical(2'd1);
    hold_recv = 1'b1;
    fork
      begin
        n = 0;
        while (n < 3000) begin
          @(posedge clk);
          n++;
        end
        hold_recv = 1'b0;
      end
      begin
        repeat (6) send_word(1'($urandom), 19'($urandom));
      end
    join
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_CAL_A;
    cfg_data = '0;
    cal_a = '0; cal_b = '0; cal_c = '0; oss_set = 2'd1; kept_b5 = '0;
    hold_recv = 1'b0;
    words_sent = 0;
    send_gap_pct = 29; recv_gap_pct = 57;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random(600, 1'b0);
    send_gap_pct = 57; recv_gap_pct = 29;
    test_random(600, 1'b1);
    test_backpressure();
    send_gap_pct = 0; recv_gap_pct = 0;
    test_random(600, 1'b0);
    test_random(100, 1'b1);
    $display("sent %0d words, checked %0d results, %0d flagged invalid", words_sent,
             words_checked, bad_seen);
    $display("covered reset defaults, zero divisors, extreme and random calibration");
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
